/* hdl/ebmt_pkg.sv */
// ----------------------------------------------------------------------------
// ebmt_pkg: shared widths, constants and register indexes
// Common definitions for the dual-average band-pass min/max tracker.
// ----------------------------------------------------------------------------
package ebmt_pkg;

  // Fractional bits of the averaging gains (range 4..16)
  localparam int GAIN_FRAC_BITS = 8;

  localparam int SAMPLE_W = 10;
  localparam int NOW_W    = 32;
  localparam int ALPHA_W  = 9;
  localparam int WIN_W    = 16;

  // Gain width wide enough for the alpha register and for unity gain
  localparam int GAIN_W = (GAIN_FRAC_BITS + 1 > ALPHA_W) ? GAIN_FRAC_BITS + 1 : ALPHA_W;
  localparam int ACC_W  = GAIN_W + SAMPLE_W + 2;

  localparam int ENH_W  = SAMPLE_W + 2;  // sample + fast - slow, signed
  localparam int STAT_W = SAMPLE_W + 1;  // min/max trackers

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LOW  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_HIGH = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS  = CFG_IDX_W'(2);

  localparam logic [ALPHA_W-1:0] ALPHA_LOW_RST  = ALPHA_W'(77);
  localparam logic [ALPHA_W-1:0] ALPHA_HIGH_RST = ALPHA_W'(102);
  localparam logic [WIN_W-1:0]   WINDOW_MS_RST  = WIN_W'(5000);

  // Window trackers restart at full scale / zero
  localparam logic [STAT_W-1:0] STAT_LOW_RST  = STAT_W'(2 ** SAMPLE_W - 1);
  localparam logic [STAT_W-1:0] STAT_HIGH_RST = '0;

  // Stream widths, whole bytes
  localparam int IN_DATA_W  = ((SAMPLE_W + NOW_W + 7) / 8) * 8;
  localparam int OUT_BITS   = ENH_W + 4 * STAT_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

endpackage

/* hdl/ebmt_ema_step.sv */
// ----------------------------------------------------------------------------
// ebmt_ema_step: one fixed-point exponential average update
// next = (a*x + (ONE-a)*avg) >> FRAC, computed as avg + a*(x-avg) scaled.
// ----------------------------------------------------------------------------
module ebmt_ema_step (
  input  logic [ebmt_pkg::ALPHA_W-1:0]  gain_i,
  input  logic [ebmt_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [ebmt_pkg::SAMPLE_W-1:0] avg_i,
  output logic [ebmt_pkg::SAMPLE_W-1:0] avg_o
);

  localparam int GW = ebmt_pkg::GAIN_W;
  localparam int SW = ebmt_pkg::SAMPLE_W;
  localparam int AW = ebmt_pkg::ACC_W;
  localparam int FB = ebmt_pkg::GAIN_FRAC_BITS;
  localparam logic [GW-1:0] GAIN_ONE = GW'(2 ** FB);

  logic [GW-1:0]        gain_ext;
  logic [GW-1:0]        gain_sat;
  logic signed [GW:0]   gain_s;
  logic signed [SW:0]   diff;
  logic signed [AW-1:0] prod;
  logic signed [AW-1:0] acc;

  always_comb begin
    gain_ext = GW'(gain_i);
    // gains above unity saturate so the average stays in range
    gain_sat = (gain_ext > GAIN_ONE) ? GAIN_ONE : gain_ext;
    gain_s   = $signed({1'b0, gain_sat});
    diff     = $signed({1'b0, sample_i}) - $signed({1'b0, avg_i});
    prod     = AW'(gain_s) * AW'(diff);
    acc      = $signed({{(AW - SW - FB){1'b0}}, avg_i, {FB{1'b0}}}) + prod;
    // acc is never negative, so the slice is the truncated quotient
    avg_o    = acc[FB +: SW];
  end

endmodule

/* hdl/ema_bandpass_minmax_tracker.sv */
// ----------------------------------------------------------------------------
// ema_bandpass_minmax_tracker: band-pass enhancer with window/overall peaks
// Top level; input register, combinational update, output register.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one item per sample: tdata[9:0] sample, [41:10] now_ms.
//   m_axis returns one item per input item: enhanced, window min/max and
//   overall min/max in tdata, window_restarted in tuser.
//   cfg_* writes a register by index (0 alpha_low, 1 alpha_high,
//   2 window_ms); cfg_ready_o is always high. Write only while idle.
// Timing:
//   An item is captured in the input register, then combinational logic
//   (one small multiply per average, add, compares) updates the state and
//   loads the output register, whose valid flag drives tvalid.
//   Throughput is one item per clock while the output stage is not held
//   by m_axis_tready; the state recurrence closes within that update.
// Reset:
//   Averages clear to zero, low trackers to 1023, high trackers and the
//   window start to zero, gains to 77/102 and the window to 5000 ms.
// Stall:
//   When m_axis_tready is low the result holds; one further item waits in
//   the input register, after which s_axis_tready drops.
// ----------------------------------------------------------------------------
module ema_bandpass_minmax_tracker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [ebmt_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // sample, now_ms, pad
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [ebmt_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // enhanced, window_min,
                                                             // window_max, overall_min,
                                                             // overall_max
  output logic                                m_axis_tuser,  // window_restarted
  // configuration
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ebmt_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ebmt_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int SW  = ebmt_pkg::SAMPLE_W;
  localparam int NW  = ebmt_pkg::NOW_W;
  localparam int EW  = ebmt_pkg::ENH_W;
  localparam int TW  = ebmt_pkg::STAT_W;
  localparam int AW  = ebmt_pkg::ALPHA_W;
  localparam int WW  = ebmt_pkg::WIN_W;
  localparam int ODW = ebmt_pkg::OUT_DATA_W;

  // configuration registers
  logic [AW-1:0] alpha_low_q, alpha_high_q;
  logic [WW-1:0] window_ms_q;

  // input stage
  logic          in_valid_q;
  logic [SW-1:0] in_sample_q;
  logic [NW-1:0] in_now_q;

  // tracker state
  logic [SW-1:0]        slow_q, fast_q;
  logic signed [TW-1:0] win_low_q, all_low_q;
  logic [TW-1:0]        win_high_q, all_high_q;
  logic [NW-1:0]        win_start_q;

  // output stage
  logic           out_valid_q;
  logic [ODW-1:0] out_data_q;
  logic           out_restart_q;

  // datapath
  logic                 out_free;
  logic                 advance;
  logic [SW-1:0]        slow_d, fast_d;
  logic signed [EW-1:0] enh;
  logic signed [TW-1:0] win_low_d, all_low_d;
  logic [TW-1:0]        win_high_d, all_high_d;
  logic [NW-1:0]        elapsed;
  logic                 restart;

  assign cfg_ready_o   = 1'b1;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_restart_q;

  ebmt_ema_step u_slow (
    .gain_i   (alpha_low_q),
    .sample_i (in_sample_q),
    .avg_i    (slow_q),
    .avg_o    (slow_d)
  );

  ebmt_ema_step u_fast (
    .gain_i   (alpha_high_q),
    .sample_i (in_sample_q),
    .avg_i    (fast_q),
    .avg_o    (fast_d)
  );

  always_comb begin
    enh = $signed({2'b00, in_sample_q}) + $signed({2'b00, fast_d})
        - $signed({2'b00, slow_d});

    // lows only ever take values below 1023 and highs values above zero,
    // so the narrower slices are exact
    win_low_d  = (enh < EW'(win_low_q)) ? enh[TW-1:0] : win_low_q;
    all_low_d  = (enh < EW'(all_low_q)) ? enh[TW-1:0] : all_low_q;
    win_high_d = (enh > $signed({1'b0, win_high_q})) ? enh[TW-1:0] : win_high_q;
    all_high_d = (enh > $signed({1'b0, all_high_q})) ? enh[TW-1:0] : all_high_q;

    elapsed = in_now_q - win_start_q;
    restart = elapsed > NW'(window_ms_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_low_q  <= ebmt_pkg::ALPHA_LOW_RST;
      alpha_high_q <= ebmt_pkg::ALPHA_HIGH_RST;
      window_ms_q  <= ebmt_pkg::WINDOW_MS_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ebmt_pkg::CFG_ALPHA_LOW:  alpha_low_q  <= cfg_data_i[AW-1:0];
        ebmt_pkg::CFG_ALPHA_HIGH: alpha_high_q <= cfg_data_i[AW-1:0];
        ebmt_pkg::CFG_WINDOW_MS:  window_ms_q  <= cfg_data_i[WW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      slow_q      <= '0;
      fast_q      <= '0;
      win_low_q   <= ebmt_pkg::STAT_LOW_RST;
      win_high_q  <= ebmt_pkg::STAT_HIGH_RST;
      all_low_q   <= ebmt_pkg::STAT_LOW_RST;
      all_high_q  <= ebmt_pkg::STAT_HIGH_RST;
      win_start_q <= '0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
      if (advance) begin
        slow_q     <= slow_d;
        fast_q     <= fast_d;
        all_low_q  <= all_low_d;
        all_high_q <= all_high_d;
        if (restart) begin
          win_low_q   <= ebmt_pkg::STAT_LOW_RST;
          win_high_q  <= ebmt_pkg::STAT_HIGH_RST;
          win_start_q <= in_now_q;
        end else begin
          win_low_q  <= win_low_d;
          win_high_q <= win_high_d;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_sample_q <= s_axis_tdata[SW-1:0];
      in_now_q    <= s_axis_tdata[SW +: NW];
    end
    if (advance) begin
      out_data_q    <= ODW'({all_high_d, all_low_d, win_high_d, win_low_d, enh});
      out_restart_q <= restart;
    end
  end

  // overall min never exceeds window min, overall max never falls below window max, enhanced lies within window
  a_overall_low_le_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $signed(m_axis_tdata[EW+2*TW +: TW]) <= $signed(m_axis_tdata[EW +: TW]))
    else $error("overall min above window min");

  a_overall_high_ge_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[EW+3*TW +: TW] >= m_axis_tdata[EW+TW +: TW])
    else $error("overall max below window max");

  a_enh_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[EW-1:0]) >= EW'($signed(m_axis_tdata[EW +: TW]))
      && $signed(m_axis_tdata[EW-1:0]) <= $signed({1'b0, m_axis_tdata[EW+TW +: TW]})))
    else $error("enhanced value outside window min/max");

  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && restart) |=> (win_low_q == ebmt_pkg::STAT_LOW_RST
      && win_high_q == ebmt_pkg::STAT_HIGH_RST && m_axis_tuser))
    else $error("window restart did not clear trackers");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready)
    else $error("input stalled with empty output stage");

endmodule

/* tb/ebmt_peak_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ebmt_peak_checker: predicts and checks the tracker's result items
// Follows register writes and accepted input items, runs its own model of
// both averages, the window restart and the peak trackers, and compares each
// result item, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module ebmt_peak_checker
  import ebmt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // sample, now_ms, pad
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,   // enhanced, window_min, window_max,
                                                // overall_min, overall_max
  input  logic                  m_axis_tuser,   // window_restarted
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    errors_o,
  output int                    pending_o
);

  localparam int unsigned GAIN_UNITY = 1 << GAIN_FRAC_BITS;

  localparam int WMIN_LSB = ENH_W;
  localparam int WMAX_LSB = ENH_W + STAT_W;
  localparam int OMIN_LSB = ENH_W + 2 * STAT_W;
  localparam int OMAX_LSB = ENH_W + 3 * STAT_W;

  typedef struct packed {
    logic [ENH_W-1:0]  enhanced;
    logic [STAT_W-1:0] window_min;
    logic [STAT_W-1:0] window_max;
    logic [STAT_W-1:0] overall_min;
    logic [STAT_W-1:0] overall_max;
    logic              restarted;
  } peak_report_t;

  peak_report_t        expected_peaks[$];

  logic [ALPHA_W-1:0]  slow_gain;
  logic [ALPHA_W-1:0]  fast_gain;
  logic [WIN_W-1:0]    window_len;
  logic [SAMPLE_W-1:0] slow_avg;
  logic [SAMPLE_W-1:0] fast_avg;
  logic [NOW_W-1:0]    win_start;
  int                  win_lo, win_hi, all_lo, all_hi;
  int                  result_cnt;

  task automatic report_error(input string msg);
    $display("%0t ns peak check: %s", $time, msg);
    errors_o++;
  endtask

  // gains above unity saturate, so the average never leaves 0..1023
  function automatic logic [SAMPLE_W-1:0] ema_next(input logic [ALPHA_W-1:0]  gain,
                                                    input logic [SAMPLE_W-1:0] x,
                                                    input logic [SAMPLE_W-1:0] prev);
    int unsigned a;
    int unsigned acc;
    a   = (gain > GAIN_UNITY) ? GAIN_UNITY : int'(gain);
    acc = a * x + (GAIN_UNITY - a) * prev;
    return SAMPLE_W'(acc >> GAIN_FRAC_BITS);
  endfunction

  task automatic predict_peaks(input logic [SAMPLE_W-1:0] x, input logic [NOW_W-1:0] now);
    int               enh;
    peak_report_t     p;
    logic [NOW_W-1:0] age;
    slow_avg = ema_next(slow_gain, x, slow_avg);
    fast_avg = ema_next(fast_gain, x, fast_avg);
    enh      = int'(x) + int'(fast_avg) - int'(slow_avg);
    if (enh < win_lo) win_lo = enh;
    if (enh > win_hi) win_hi = enh;
    if (enh < all_lo) all_lo = enh;
    if (enh > all_hi) all_hi = enh;
    p.enhanced    = ENH_W'(enh);
    p.window_min  = STAT_W'(win_lo);
    p.window_max  = STAT_W'(win_hi);
    p.overall_min = STAT_W'(all_lo);
    p.overall_max = STAT_W'(all_hi);
    // reported window values are from before the restart
    age         = now - win_start;
    p.restarted = (age > NOW_W'(window_len));
    if (p.restarted) begin
      win_start = now;
      win_lo    = int'(STAT_LOW_RST);
      win_hi    = int'(STAT_HIGH_RST);
    end
    expected_peaks.push_back(p);
  endtask

  task automatic check_field(input string name, input logic [ENH_W-1:0] got,
                             input logic [ENH_W-1:0] want);
    if (got !== want)
      report_error($sformatf("result %0d %s got %0h want %0h", result_cnt, name, got, want));
  endtask

  task automatic check_result();
    peak_report_t want;
    if (expected_peaks.size() == 0) begin
      report_error($sformatf("result %0d arrived with none expected", result_cnt));
    end else begin
      want = expected_peaks.pop_front();
      check_field("enhanced",    m_axis_tdata[0 +: ENH_W], want.enhanced);
      check_field("window_min",  ENH_W'(m_axis_tdata[WMIN_LSB +: STAT_W]),
                  ENH_W'(want.window_min));
      check_field("window_max",  ENH_W'(m_axis_tdata[WMAX_LSB +: STAT_W]),
                  ENH_W'(want.window_max));
      check_field("overall_min", ENH_W'(m_axis_tdata[OMIN_LSB +: STAT_W]),
                  ENH_W'(want.overall_min));
      check_field("overall_max", ENH_W'(m_axis_tdata[OMAX_LSB +: STAT_W]),
                  ENH_W'(want.overall_max));
      check_field("window_restarted", ENH_W'(m_axis_tuser), ENH_W'(want.restarted));
    end
    result_cnt++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_peaks.delete();
      slow_gain  = ALPHA_LOW_RST;
      fast_gain  = ALPHA_HIGH_RST;
      window_len = WINDOW_MS_RST;
      slow_avg   = '0;
      fast_avg   = '0;
      win_start  = '0;
      win_lo     = int'(STAT_LOW_RST);
      win_hi     = int'(STAT_HIGH_RST);
      all_lo     = int'(STAT_LOW_RST);
      all_hi     = int'(STAT_HIGH_RST);
      result_cnt = 0;
      errors_o   = 0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_ALPHA_LOW:  slow_gain  = cfg_data_i[ALPHA_W-1:0];
          CFG_ALPHA_HIGH: fast_gain  = cfg_data_i[ALPHA_W-1:0];
          CFG_WINDOW_MS:  window_len = cfg_data_i[WIN_W-1:0];
          default: ;  // unmapped index, write dropped
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (s_axis_tvalid && s_axis_tready)
        predict_peaks(s_axis_tdata[SAMPLE_W-1:0], s_axis_tdata[SAMPLE_W +: NOW_W]);
      pending_o <= expected_peaks.size();
    end
  end

endmodule

/* tb/ema_bandpass_minmax_tracker_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ema_bandpass_minmax_tracker_tb: stimulus and verdict for the tracker
// Directed items for gain, window and range corner cases, then random phases
// of sample streams under random settings, with bursty input and a stalling
// receiver. Checking is done by the peak checker instantiated alongside.
// ----------------------------------------------------------------------------
module ema_bandpass_minmax_tracker_tb;
  import ebmt_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(3);
  localparam int CYCLE_LIMIT = 400000;
  localparam int LATENCY     = 4;
  localparam int RAND_ITEMS  = 1250;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;   // sample, now_ms, pad
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;         // enhanced, window_min, window_max,
                                               // overall_min, overall_max
  logic                  m_axis_tuser;         // window_restarted
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  int checker_errors;
  int results_due;
  int burst_left = 0;
  int cycle_cnt  = 0;

  always #4 clk_i = ~clk_i;

  ema_bandpass_minmax_tracker u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  ebmt_peak_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .errors_o      (checker_errors),
    .pending_o     (results_due)
  );

  // receiver backpressure: modes of random length
  always @(posedge clk_i) begin : rx_stall
    rx_mode_e mode;
    int       left;
    int       tick;
    if (left <= 0) begin
      mode = rx_mode_e'($urandom_range(0, 3));
      left = $urandom_range(32, 400);
    end
    left--;
    tick++;
    case (mode)
      RX_OPEN:     m_axis_tready <= 1'b1;
      RX_COIN:     m_axis_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE:   m_axis_tready <= ($urandom_range(0, 7) == 0);
      RX_PERIODIC: m_axis_tready <= ((tick % 7) < 3);
      default:     m_axis_tready <= 1'b1;
    endcase
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("ema_bandpass_minmax_tracker_tb: errors");
      $finish;
    end
  end

  task automatic send_item(input logic [SAMPLE_W-1:0] smp, input logic [NOW_W-1:0] ts);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_W'({ts, smp});
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // hold input until every predicted item has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (results_due != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return CFG_DATA_W'(256);
      2:       return CFG_DATA_W'($urandom_range(257, 511));
      3:       return CFG_DATA_W'($urandom_range(1, 255));
      default: return CFG_DATA_W'($urandom());
    endcase
  endfunction

  initial begin : stimulus
    logic [SAMPLE_W-1:0] smp;
    logic [NOW_W-1:0]    ts;
    logic [WIN_W-1:0]    win;
    int                  step_max, n, r, v, rand_cnt;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // default settings: field extremes and window edge, wrap of the timestamp
    send_item(10'd0,    32'd0);
    send_item(10'd1023, 32'd1);
    send_item(10'd1023, 32'd4999);
    send_item(10'h2AA,  32'd5000);          // exactly the window: no restart
    send_item(10'h155,  32'd5001);
    send_item(10'd512,  32'hFFFF_FFFF);
    send_item(10'd300,  32'h0000_1000);     // wrapped difference inside window
    send_item(10'd1023, 32'h0000_1388);

    // drive enhanced to its lowest value: slow at full scale, fast and sample at zero
    drain();
    cfg_write(CFG_ALPHA_LOW,  16'd256);
    cfg_write(CFG_ALPHA_HIGH, 16'd256);
    send_item(10'd0, 32'h0000_2000);
    drain();
    cfg_write(CFG_ALPHA_HIGH, 16'd0);       // fast average holds
    send_item(10'd1023, 32'h0000_2001);
    drain();
    cfg_write(CFG_ALPHA_LOW, 16'd0);
    send_item(10'd0, 32'h0000_2002);

    // and to its highest, with gains above unity
    drain();
    cfg_write(CFG_ALPHA_LOW,  16'd256);
    cfg_write(CFG_ALPHA_HIGH, 16'd256);
    send_item(10'd0, 32'h0000_2003);
    drain();
    cfg_write(CFG_ALPHA_LOW,  16'd0);
    cfg_write(CFG_ALPHA_HIGH, 16'h01FF);
    send_item(10'd1023, 32'h0000_2004);
    drain();
    cfg_write(CFG_ALPHA_LOW,  16'h0140);
    cfg_write(CFG_ALPHA_HIGH, 16'h012C);
    send_item(10'd1023, 32'h0000_2005);

    // zero window: restart on any change of timestamp
    drain();
    cfg_write(CFG_WINDOW_MS, 16'd0);
    send_item(10'd700, 32'h0000_3000);
    send_item(10'd5,   32'h0000_3000);
    send_item(10'd900, 32'h0000_3001);

    // unmapped index must not disturb anything; widest window
    drain();
    cfg_write(CFG_UNUSED,    16'hFFFF);
    cfg_write(CFG_WINDOW_MS, 16'hFFFF);
    send_item(10'd1023, 32'h0001_3000);
    send_item(10'd0,    32'h0001_3001);

    ts       = 32'h0001_3001;
    smp      = '0;
    rand_cnt = 0;
    while (rand_cnt < RAND_ITEMS) begin
      drain();
      win = CFG_DATA_W'($urandom());
      case ($urandom_range(0, 4))
        0:       win = '0;
        1:       win = '1;
        2:       win = WIN_W'($urandom_range(1, 40));
        3:       win = WIN_W'($urandom_range(41, 2000));
        default: ;
      endcase
      cfg_write(CFG_ALPHA_LOW,  pick_gain());
      cfg_write(CFG_ALPHA_HIGH, pick_gain());
      cfg_write(CFG_WINDOW_MS,  win);
      if ($urandom_range(0, 3) == 0) cfg_write(CFG_UNUSED, CFG_DATA_W'($urandom()));
      step_max = int'(win) / 4 + 2;
      if ($urandom_range(0, 3) == 0) ts = 32'hFFFF_FFFF - $urandom_range(0, 2000);
      n = $urandom_range(120, 190);
      repeat (n) begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          smp = SAMPLE_W'($urandom());
        end else if (r < 70) begin
          v = int'(smp) + int'($urandom_range(0, 32)) - 16;
          smp = (v < 0) ? '0 : (v > 1023) ? 10'd1023 : SAMPLE_W'(v);
        end else if (r < 85) begin
          smp = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
        end
        r = $urandom_range(0, 99);
        if (r < 80)      ts = ts + $urandom_range(0, step_max);
        else if (r < 92) ts = ts + $urandom_range(0, 2);
        else             ts = $urandom();
        send_item(smp, ts);
        rand_cnt++;
        if ($urandom_range(0, 199) == 0) drain();
      end
    end

    drain();
    if (checker_errors == 0 && results_due == 0)
      $display("ema_bandpass_minmax_tracker_tb: clean");
    else
      $display("ema_bandpass_minmax_tracker_tb: errors");
    $finish;
  end

endmodule
